### rtl/core/pxh_pkg.sv
package pxh_pkg;

   localparam int HASH_WIDTH    = 20;
   localparam int STORE_DEPTH   = 65536;
   localparam int WINDOW_PIXELS = 1048456;
   localparam int LONGEST_MATCH = 4096;

   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int ENTRY_W  = ADDR_W + 1;
   localparam int HASH_ENTRIES = 1 << HASH_WIDTH;
   localparam int LEN_W    = 13;
   localparam int VAL_W    = 30;
   localparam int GIVE_W   = 10;
   localparam int WIDTH_W  = 15;
   localparam int MINPOS_W = 21;

   localparam logic [63:0] HASH_MUL = 64'hc6a4a7935bd1e995;
   localparam logic [GIVE_W-1:0] GIVE_UP_SOFT = GIVE_W'(101);
   localparam logic [GIVE_W-1:0] GIVE_UP_HARD = GIVE_W'(1001);
   localparam logic signed [VAL_W-1:0] GOOD_ENOUGH = VAL_W'(32'h00ff0000);
   localparam logic [7:0] FAR_PENALTY = 8'(9 * 9 + 9 * 9);
   localparam logic [LEN_W-1:0] SHORT_STOP = LEN_W'(128);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LONGEST_MATCH);

   typedef enum logic [1:0] {
      OP_STORE  = 2'd0,
      OP_INSERT = 2'd1,
      OP_FIND   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_RD,
      ST_MUL,
      ST_HEAD_RD,
      ST_HEAD_DATA,
      ST_LOOP,
      ST_CHECK,
      ST_MATCH_RD,
      ST_MATCH_CMP,
      ST_DIST,
      ST_DIV,
      ST_FOLD,
      ST_SCORE,
      ST_DONE
   } state_type;

endpackage

### rtl/core/pixel_hash_chain_match_finder.sv
// LZ77 hash-chain match finder over 32-bit ARGB pixels. After reset the block runs a clearing
// pass over all 2^20 entries of the hash head store, one entry a cycle, and holds req_stall
// high meanwhile; write image_width only while no item is in flight. A store leaves the block
// idle, so the next transfer can be taken straight after it. An insert holds req_stall high
// after its transfer through one pixel pair read, the steps that build the 64-bit hash product
// from three 32x32 partial products on one shared multiplier, then the head read and the head
// and link writes. A find runs the same steps but for the writes, then per chain candidate the
// link and quick-reject reads, a match length loop that reads and compares one pixel pair per
// matching pixel, and the offset split into row and column (a 3-step shared subtract) and
// scoring; the walk visits at most 1000 entries and ends in the done state, which holds until
// the rsp register can be loaded. Only one item is in flight; a finished result waits in the
// rsp register while the next item is accepted.
module pixel_hash_chain_match_finder (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [31:0]                  req_pixel_value,
   input  logic [15:0]                  req_position,
   input  logic [12:0]                  req_max_len,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [15:0]                  rsp_match_offset,
   output logic [12:0]                  rsp_match_length,
   output logic                         rsp_found,
   input  logic                         csr_wr_en,
   input  logic [pxh_pkg::WIDTH_W-1:0]  csr_wr_data
);
   import pxh_pkg::*;

   state_type state_ff, state_in;
   op_type op_ff, op_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] limit_ff, limit_in;
   logic [WIDTH_W-1:0] width_ff;
   logic [HASH_WIDTH-1:0] clr_ff, clr_in;
   logic [1:0] mstep_ff, mstep_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] mul_ff, mul_in;
   logic [ENTRY_W-1:0] entry_ff, entry_in;
   logic [ADDR_W-1:0] cand_ff, cand_in;
   logic [GIVE_W-1:0] give_ff, give_in;
   logic [LEN_W-1:0] best_len_ff, best_len_in;
   logic [ADDR_W-1:0] best_off_ff, best_off_in;
   logic signed [VAL_W-1:0] lead_score_ff, lead_score_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic [ADDR_W-1:0] dist_ff, dist_in;
   logic [ADDR_W-1:0] rem_ff, rem_in;
   logic [2:0] y_ff, y_in;
   logic far_ff, far_in;
   logic [1:0] dstep_ff, dstep_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_off_ff, rsp_off_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;

   logic req_take, rsp_load;
   logic [WIDTH_W-1:0] weff;
   logic [HASH_WIDTH-1:0] hash;
   logic [ADDR_W-1:0] cand_w;
   logic [GIVE_W-1:0] give_nx;
   logic [MINPOS_W-1:0] min_pos;
   logic [31:0] mul_a, mul_b;
   logic [17:0] wsh;
   logic [ADDR_W-1:0] xv;
   logic [6:0] pen_near;
   logic [7:0] pen;
   logic signed [VAL_W-1:0] val;
   logic stop_loop;

   logic pa_rd_en, pb_rd_en, pix_wr_en;
   logic [ADDR_W-1:0] pa_addr, pb_addr;
   logic [31:0] pa_data, pb_data;
   logic head_wr_en, head_rd_en;
   logic [HASH_WIDTH-1:0] head_wr_addr;
   logic [ENTRY_W-1:0] head_wr_data, head_data;
   logic link_wr_en, link_rd_en;
   logic [ENTRY_W-1:0] link_data;

   pxh_ram #(.DEPTH(STORE_DEPTH), .WIDTH(32)) u_pix_a (
      .clock(clock), .wr_en(pix_wr_en), .wr_addr(ADDR_W'(req_position)),
      .wr_data(req_pixel_value), .rd_en(pa_rd_en), .rd_addr(pa_addr), .rd_data(pa_data)
   );

   pxh_ram #(.DEPTH(STORE_DEPTH), .WIDTH(32)) u_pix_b (
      .clock(clock), .wr_en(pix_wr_en), .wr_addr(ADDR_W'(req_position)),
      .wr_data(req_pixel_value), .rd_en(pb_rd_en), .rd_addr(pb_addr), .rd_data(pb_data)
   );

   pxh_ram #(.DEPTH(HASH_ENTRIES), .WIDTH(ENTRY_W)) u_head (
      .clock(clock), .wr_en(head_wr_en), .wr_addr(head_wr_addr), .wr_data(head_wr_data),
      .rd_en(head_rd_en), .rd_addr(hash), .rd_data(head_data)
   );

   pxh_ram #(.DEPTH(STORE_DEPTH), .WIDTH(ENTRY_W)) u_link (
      .clock(clock), .wr_en(link_wr_en), .wr_addr(pos_ff), .wr_data(head_data),
      .rd_en(link_rd_en), .rd_addr(cand_w), .rd_data(link_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign weff      = (width_ff == '0) ? WIDTH_W'(1) : width_ff;
   assign hash      = acc_ff[63 -: HASH_WIDTH];
   assign cand_w    = ADDR_W'(entry_ff - ENTRY_W'(1));
   assign give_nx   = give_ff + GIVE_W'(1);
   assign min_pos   = (MINPOS_W'(pos_ff) > MINPOS_W'(WINDOW_PIXELS)) ?
                      MINPOS_W'(pos_ff) - MINPOS_W'(WINDOW_PIXELS) : '0;
   assign stop_loop = (entry_ff == '0) || (MINPOS_W'(cand_w) < min_pos) ||
                      ((give_nx >= GIVE_UP_SOFT) &&
                       ((give_nx >= GIVE_UP_HARD) || (lead_score_ff >= GOOD_ENOUGH)));
   assign wsh       = 18'(weff) << dstep_ff;
   assign xv        = rem_ff;
   assign pen_near  = (7'(y_ff) * 7'(y_ff)) + (7'(xv[2:0]) * 7'(xv[2:0]));
   assign pen       = (far_ff || (xv > ADDR_W'(7))) ? FAR_PENALTY : 8'(pen_near);
   assign val       = $signed({1'b0, n_ff, 16'b0}) - $signed(VAL_W'(pen));

   // shared multiplier operand select
   always_comb begin
      mul_a = pa_data;
      mul_b = HASH_MUL[31:0];
      case (mstep_ff)
         2'd1: begin
            mul_a = pb_data;
            mul_b = HASH_MUL[31:0];
         end
         2'd2: begin
            mul_a = pa_data;
            mul_b = HASH_MUL[63:32];
         end
         default: begin
            mul_a = pa_data;
            mul_b = HASH_MUL[31:0];
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:     if (clr_ff == HASH_WIDTH'(HASH_ENTRIES - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_take && (req_op == OP_INSERT || req_op == OP_FIND)) begin
               state_in = ST_HASH_RD;
            end
         end
         ST_HASH_RD:   state_in = ST_MUL;
         ST_MUL:       if (mstep_ff == 2'd3) state_in = ST_HEAD_RD;
         ST_HEAD_RD:   state_in = ST_HEAD_DATA;
         ST_HEAD_DATA: state_in = (op_ff == OP_FIND) ? ST_LOOP : ST_IDLE;
         ST_LOOP:      state_in = stop_loop ? ST_DONE : ST_CHECK;
         ST_CHECK: begin
            if (cand_ff >= pos_ff) begin
               state_in = ST_LOOP;
            end else if (best_len_ff != '0 && pa_data != pb_data) begin
               state_in = ST_LOOP;
            end else begin
               state_in = ST_MATCH_RD;
            end
         end
         ST_MATCH_RD:  state_in = (n_ff < limit_ff) ? ST_MATCH_CMP : ST_DIST;
         ST_MATCH_CMP: state_in = (pa_data == pb_data) ? ST_MATCH_RD : ST_DIST;
         ST_DIST:      state_in = ST_DIV;
         ST_DIV:       if (dstep_ff == 2'd0) state_in = ST_FOLD;
         ST_FOLD:      state_in = ST_SCORE;
         ST_SCORE: begin
            state_in = ST_LOOP;
            if (lead_score_ff < val) begin
               if (n_ff >= MAX_LEN) begin
                  state_in = ST_DONE;
               end else if ((dist_ff == ADDR_W'(1) || dist_ff == ADDR_W'(weff)) &&
                            n_ff >= SHORT_STOP) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE:      if (rsp_load) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      op_in       = op_ff;
      pos_in      = pos_ff;
      limit_in    = limit_ff;
      clr_in      = clr_ff;
      mstep_in    = mstep_ff;
      acc_in      = acc_ff;
      mul_in      = mul_ff;
      entry_in    = entry_ff;
      cand_in     = cand_ff;
      give_in     = give_ff;
      best_len_in = best_len_ff;
      best_off_in = best_off_ff;
      lead_score_in = lead_score_ff;
      n_in        = n_ff;
      dist_in     = dist_ff;
      rem_in      = rem_ff;
      y_in        = y_ff;
      far_in      = far_ff;
      dstep_in    = dstep_ff;
      rsp_off_in  = rsp_off_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      pix_wr_en    = 1'b0;
      pa_rd_en     = 1'b0;
      pb_rd_en     = 1'b0;
      pa_addr      = pos_ff;
      pb_addr      = pos_ff;
      head_wr_en   = 1'b0;
      head_rd_en   = 1'b0;
      head_wr_addr = hash;
      head_wr_data = ENTRY_W'(pos_ff) + ENTRY_W'(1);
      link_wr_en   = 1'b0;
      link_rd_en   = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            head_wr_en   = 1'b1;
            head_wr_addr = clr_ff;
            head_wr_data = '0;
            clr_in       = clr_ff + HASH_WIDTH'(1);
         end
         ST_IDLE: begin
            if (req_take) begin
               op_in    = op_type'(req_op);
               pos_in   = ADDR_W'(req_position);
               limit_in = (req_max_len > MAX_LEN) ? MAX_LEN : req_max_len;
               pix_wr_en = (req_op == OP_STORE);
            end
            mstep_in    = '0;
            give_in     = '0;
            best_len_in = '0;
            best_off_in = '0;
            lead_score_in = '0;
         end
         ST_HASH_RD: begin
            pa_rd_en = 1'b1;
            pb_rd_en = 1'b1;
            pa_addr  = pos_ff;
            pb_addr  = pos_ff + ADDR_W'(1);
         end
         ST_MUL: begin
            mstep_in = mstep_ff + 2'd1;
            mul_in   = 64'(mul_a) * 64'(mul_b);
            case (mstep_ff)
               2'd0:    acc_in = acc_ff;
               2'd1:    acc_in = mul_ff;
               default: acc_in = {acc_ff[63:32] + mul_ff[31:0], acc_ff[31:0]};
            endcase
         end
         ST_HEAD_RD: begin
            head_rd_en = 1'b1;
         end
         ST_HEAD_DATA: begin
            entry_in = head_data;
            if (op_ff == OP_INSERT) begin
               link_wr_en = 1'b1;
               head_wr_en = 1'b1;
            end
         end
         ST_LOOP: begin
            cand_in    = cand_w;
            give_in    = give_nx;
            link_rd_en = 1'b1;
            pa_rd_en   = 1'b1;
            pb_rd_en   = 1'b1;
            pa_addr    = cand_w + ADDR_W'(best_len_ff) - ADDR_W'(1);
            pb_addr    = pos_ff + ADDR_W'(best_len_ff) - ADDR_W'(1);
         end
         ST_CHECK: begin
            entry_in = link_data;
            n_in     = '0;
         end
         ST_MATCH_RD: begin
            pa_rd_en = 1'b1;
            pb_rd_en = 1'b1;
            pa_addr  = cand_ff + ADDR_W'(n_ff);
            pb_addr  = pos_ff + ADDR_W'(n_ff);
         end
         ST_MATCH_CMP: begin
            if (pa_data == pb_data) n_in = n_ff + LEN_W'(1);
         end
         ST_DIST: begin
            dist_in  = pos_ff - cand_ff;
            rem_in   = pos_ff - cand_ff;
            far_in   = 18'(pos_ff - cand_ff) >= {weff, 3'b0};
            y_in     = '0;
            dstep_in = 2'd2;
         end
         ST_DIV: begin
            dstep_in = dstep_ff - 2'd1;
            if (18'(rem_ff) >= wsh) begin
               rem_in = rem_ff - ADDR_W'(wsh);
               y_in   = y_ff | (3'd1 << dstep_ff);
            end
         end
         ST_FOLD: begin
            if (rem_ff > ADDR_W'(weff >> 1)) rem_in = ADDR_W'(weff) - rem_ff;
         end
         ST_SCORE: begin
            if (lead_score_ff < val) begin
               lead_score_in = val;
               best_len_in = n_ff;
               best_off_in = dist_ff;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = best_off_ff;
               rsp_len_in   = best_len_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= WIDTH_W'(1);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) width_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      limit_ff    <= limit_in;
      mstep_ff    <= mstep_in;
      acc_ff      <= acc_in;
      mul_ff      <= mul_in;
      entry_ff    <= entry_in;
      cand_ff     <= cand_in;
      give_ff     <= give_in;
      best_len_ff <= best_len_in;
      best_off_ff <= best_off_in;
      lead_score_ff <= lead_score_in;
      n_ff        <= n_in;
      dist_ff     <= dist_in;
      rem_ff      <= rem_in;
      y_ff        <= y_in;
      far_ff      <= far_in;
      dstep_ff    <= dstep_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_len_ff  <= rsp_len_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_match_offset = 16'(rsp_off_ff);
   assign rsp_match_length = rsp_len_ff;
   assign rsp_found        = (rsp_len_ff >= LEN_W'(2));

endmodule

### rtl/core/pxh_ram.sv
module pxh_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### verif/tb_pixel_hash_chain_match_finder.sv
module tb_pixel_hash_chain_match_finder;
   timeunit 1ns;
   timeprecision 1ps;
   import pxh_pkg::*;

   class match_scoreboard;
      typedef struct {
         bit [15:0] offset;
         bit [12:0] length;
         bit        found;
      } match_type;

      localparam longint GOOD_SCORE = 64'h0000_0000_00ff_0000;

      bit [31:0]   pixels[65536];
      bit          written[65536];
      bit          touched_unwritten;
      int unsigned heads[int unsigned];
      int unsigned links[65536];
      int unsigned width = 1;
      match_type   pending[$];
      int          errors = 0;

      function bit [31:0] read_pixel(bit [15:0] a);
         if (!written[a]) touched_unwritten = 1'b1;
         return pixels[a];
      endfunction

      function int unsigned pair_hash(bit [15:0] p);
         bit [15:0] q;
         bit [63:0] key;
         q = p + 16'd1;
         key = {read_pixel(q), read_pixel(p)};
         key = key * HASH_MUL;
         return int'(key >> (64 - HASH_WIDTH));
      endfunction

      function int unsigned run_len(bit [15:0] a, bit [15:0] b, int unsigned lim);
         int unsigned n;
         n = 0;
         while (n < lim && read_pixel(16'(a + n)) == read_pixel(16'(b + n))) n++;
         return n;
      endfunction

      function match_type search(bit [15:0] pos, bit [12:0] ml);
         int unsigned h, entry, cand, lim, w, give, best_len, best_off, len, gap, y, x;
         longint lead_score, val;
         match_type m;
         lim = (ml > LONGEST_MATCH) ? LONGEST_MATCH : ml;
         w = (width == 0) ? 1 : width;
         give = 0;
         best_len = 0;
         best_off = 0;
         lead_score = 0;
         h = pair_hash(pos);
         entry = heads.exists(h) ? heads[h] : 0;
         while (entry != 0) begin
            cand = entry - 1;
            entry = links[cand];
            give++;
            if (give >= 101 && (give >= 1001 || lead_score >= GOOD_SCORE)) break;
            if (cand >= pos) continue;
            if (best_len != 0 && read_pixel(16'(cand + best_len - 1)) !=
                read_pixel(16'(pos + best_len - 1))) continue;
            len = run_len(16'(cand), pos, lim);
            val = 65536 * longint'(len);
            gap = pos - cand;
            y = gap / w;
            x = gap % w;
            if (y < 8) begin
               if (x > w / 2) x = w - x;
               if (x <= 7) val -= longint'(y * y + x * x);
               else val -= 162;
            end else begin
               val -= 162;
            end
            if (lead_score < val) begin
               lead_score = val;
               best_len = len;
               best_off = gap;
               if (len >= LONGEST_MATCH) break;
               if ((gap == 1 || gap == w) && len >= 128) break;
            end
         end
         m.offset = 16'(best_off);
         m.length = 13'(best_len);
         m.found = (best_len >= 2);
         return m;
      endfunction

      function bit is_safe(op_type op, bit [15:0] pos, bit [12:0] ml);
         touched_unwritten = 1'b0;
         case (op)
            OP_INSERT: void'(pair_hash(pos));
            OP_FIND:   void'(search(pos, ml));
            default: ;
         endcase
         return !touched_unwritten;
      endfunction

      function void note_transfer(op_type op, bit [31:0] pix, bit [15:0] pos, bit [12:0] ml);
         int unsigned h;
         case (op)
            OP_STORE: begin
               pixels[pos] = pix;
               written[pos] = 1'b1;
            end
            OP_INSERT: begin
               h = pair_hash(pos);
               links[pos] = heads.exists(h) ? heads[h] : 0;
               heads[h] = pos + 1;
            end
            OP_FIND: begin
               pending.push_back(search(pos, ml));
            end
            default: ;
         endcase
      endfunction

      function void check_match(bit [15:0] off, bit [12:0] len, bit fnd);
         match_type m;
         if (pending.size() == 0) begin
            $error("unexpected result transfer offset=%0d length=%0d", off, len);
            errors++;
            return;
         end
         m = pending.pop_front();
         if (m.offset != off) begin
            $error("match_offset expected %0d actual %0d", m.offset, off);
            errors++;
         end
         if (m.length != len) begin
            $error("match_length expected %0d actual %0d", m.length, len);
            errors++;
         end
         if (m.found != fnd) begin
            $error("found expected %0d actual %0d", m.found, fnd);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   logic [1:0]   req_op;
   logic [31:0]  req_pixel_value;
   logic [15:0]  req_position;
   logic [12:0]  req_max_len;
   logic         rsp_valid;
   logic         rsp_stall;
   logic [15:0]  rsp_match_offset;
   logic [12:0]  rsp_match_length;
   logic         rsp_found;
   logic         csr_wr_en;
   logic [WIDTH_W-1:0] csr_wr_data;

   match_scoreboard sb;
   bit          quiet = 0;
   bit [31:0]   palette[4];
   bit [15:0]   base;
   bit          run_base;
   int unsigned widths[6] = '{16384, 32767, 0, 1, 7, 64};

   localparam int RUN_LO   = 40000;
   localparam int RUN_LEN  = 400;
   localparam int WRAP_LO  = 65408;
   localparam int WRAP_LEN = 512;

   pixel_hash_chain_match_finder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_pixel_value(req_pixel_value), .req_position(req_position),
      .req_max_len(req_max_len),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_match_offset(rsp_match_offset), .rsp_match_length(rsp_match_length),
      .rsp_found(rsp_found),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   task automatic send(op_type op, bit [31:0] pix, bit [15:0] pos, bit [12:0] ml);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_pixel_value <= pix;
      req_position <= pos;
      req_max_len <= ml;
      do @(posedge clock); while (req_stall);
      sb.note_transfer(op, pix, pos, ml);
   endtask

   // items that would read an unwritten pixel become stores
   task automatic send_any(op_type op, bit [31:0] pix, bit [15:0] pos, bit [12:0] ml);
      if (sb.is_safe(op, pos, ml)) begin
         send(op, pix, pos, ml);
      end else begin
         send(OP_STORE, palette[$urandom_range(0, 3)], pos, ml);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_width(int unsigned v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= WIDTH_W'(v);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.width = v & 32'h7fff;
   endtask

   function automatic bit [15:0] pick_pos();
      if ($urandom_range(0, 9) < 8) return base + 16'($urandom_range(0, 299));
      return 16'($urandom);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_match(rsp_match_offset, rsp_match_length, rsp_found);
   end

   // receiver back-pressure in bursts
   initial begin
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(0, 30)) @(posedge clock);
         end
      end
   end

   initial begin
      #2_000_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int unsigned r;
      bit [12:0] ml;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_STORE;
      req_pixel_value = '0;
      req_position = '0;
      req_max_len = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      palette[0] = 32'h0000_0000;
      palette[1] = 32'hffff_ffff;
      palette[2] = $urandom;
      palette[3] = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_width(1);

      // region across the end of the store, then a run of one color
      for (int p = 0; p < WRAP_LEN; p++) begin
         send(OP_STORE, palette[$urandom_range(0, 3)], 16'(WRAP_LO + p), 0);
      end
      for (int p = 0; p < RUN_LEN; p++) begin
         send(OP_STORE, palette[2], 16'(RUN_LO + p), 0);
      end
      send(OP_STORE, ~palette[2], 16'(RUN_LO + RUN_LEN), 0);

      // directed
      send(OP_STORE, 32'h0000_0000, 16'd65535, 0);
      send(OP_STORE, 32'hffff_ffff, 16'd0, 0);
      send(OP_INSERT, 0, 16'd65535, 0);
      send(OP_FIND, 0, 16'd65535, 13'd8191);
      send(OP_FIND, 0, 16'd100, 13'd0);
      send(OP_NONE, 32'hffff_ffff, 16'hffff, 13'h1fff);
      send(OP_INSERT, 0, 16'(RUN_LO + 100), 0);
      send(OP_FIND, 0, 16'(RUN_LO + 50), 13'd20);
      send(OP_INSERT, 0, 16'(RUN_LO), 0);
      send(OP_FIND, 0, 16'(RUN_LO + 10), 13'd8191);
      send(OP_INSERT, 0, 16'(RUN_LO + 19), 0);
      send(OP_FIND, 0, 16'(RUN_LO + 20), 13'd200);
      send(OP_INSERT, 0, 16'(RUN_LO + 300), 0);
      send(OP_INSERT, 0, 16'(RUN_LO + 300), 0);
      send(OP_FIND, 0, 16'(RUN_LO + 301), 13'd3);
      drain();
      set_width(64);
      send(OP_INSERT, 0, 16'(RUN_LO + 200), 0);
      send(OP_FIND, 0, 16'(RUN_LO + 264), 13'd300);
      send(OP_FIND, 0, 16'(RUN_LO + 270), 13'd30);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         set_width(widths[ph]);
         quiet = (ph == 5);
         case ($urandom_range(0, 3))
            0: base = 16'd65420;
            1: base = 16'd0;
            2: base = 16'd60;
            default: base = 16'(RUN_LO);
         endcase
         run_base = (base == 16'(RUN_LO));
         for (int i = 0; i < 100; i++) begin
            r = $urandom_range(0, 19);
            if (!run_base && $urandom_range(0, 19) == 0) ml = 13'($urandom_range(0, 8191));
            else ml = 13'($urandom_range(0, 40));
            if (r < 6) send_any(OP_INSERT, $urandom, pick_pos(), 13'($urandom));
            else if (r < 15) send_any(OP_FIND, $urandom, pick_pos(), ml);
            else if (r < 18) send(OP_STORE, palette[$urandom_range(0, 3)], pick_pos(), ml);
            else send(OP_NONE, $urandom, 16'($urandom), 13'($urandom));
         end
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

### pixel_hash_chain_match_finder.f
rtl/core/pxh_pkg.sv
rtl/core/pxh_ram.sv
rtl/core/pixel_hash_chain_match_finder.sv
verif/tb_pixel_hash_chain_match_finder.sv
